// File: hdl/pnws_pkg.sv
package pnws_pkg;

  // default sizes
  localparam int NodesDefault     = 64;
  localparam int CountBitsDefault = 32;
  localparam int TimeBitsDefault  = 48;

  // fixed field widths
  localparam int NodeBits   = 6;
  localparam int PitchBits  = 8;
  localparam int PitchOut   = 7;
  localparam int CfgIdxBits = 2;

  // repeat index ceiling
  localparam logic [63:0] CycleLimit = 64'h0010_0000_0000_0000;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] RegSelectedNode = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegWindowFrom   = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegWindowTo     = 2'd2;
  localparam logic [CfgIdxBits-1:0] RegPerfEnd      = 2'd3;

endpackage

// File: hdl/pnws_div.sv
module pnws_div #(
  parameter int W = pnws_pkg::TimeBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-2:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic         rem_nz_o
);

  localparam int CntW = $clog2(W + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    quot_q;
  logic [W-2:0]    rem_q;
  logic [W-2:0]    dsr_q;

  logic [W-1:0]    shifted;
  logic [W:0]      diff;
  logic            ge;

  // one restoring step: shift in the next dividend bit, try to subtract
  assign shifted = {rem_q, quot_q[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_q};
  assign ge      = ~diff[W];

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // quotient and remainder datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[W-2:0], ge};
      rem_q  <= ge ? diff[W-2:0] : shifted[W-2:0];
    end
  end

  assign done_o   = done_q;
  assign quot_o   = quot_q;
  assign rem_nz_o = |rem_q;

endmodule

// File: hdl/periodic_note_window_summary.sv
// sequence: an accepted item passes through prep, clamp and accumulate, and a last item
//   also through output; a repeating item first runs three divisions, then max and subtract
// throughput: one item at a time, the next one taken only once the sequencer is idle again,
//   which after a last item waits while its result is still held; the three ceiling
//   divisions share one radix-2 divider
// reset: asynchronous, active low; clears configuration, state, sums and the output valid
module periodic_note_window_summary #(
  parameter int NODES      = pnws_pkg::NodesDefault,
  parameter int COUNT_BITS = pnws_pkg::CountBitsDefault,
  parameter int TIME_BITS  = pnws_pkg::TimeBitsDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration
  input  logic                                   cfg_we_i,
  input  logic [pnws_pkg::CfgIdxBits-1:0]        cfg_idx_i,
  input  logic [TIME_BITS-1:0]                   cfg_data_i,
  // input items
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [pnws_pkg::NodeBits-1:0]          event_node_i,
  input  logic signed [TIME_BITS-1:0]            event_start_i,
  input  logic signed [TIME_BITS-1:0]            event_end_i,
  input  logic [TIME_BITS-2:0]                   event_period_i,
  input  logic signed [pnws_pkg::PitchBits-1:0]  event_pitch_i,
  input  logic                                   is_last_i,
  // result items
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [COUNT_BITS-1:0]                  note_count_o,
  output logic [pnws_pkg::PitchOut-1:0]          lowest_pitch_o,
  output logic [pnws_pkg::PitchOut-1:0]          highest_pitch_o
);

  localparam int TW = TIME_BITS;
  localparam int KW = TW + 1;
  localparam int CW = (KW > 53) ? KW : 53;
  localparam int MW = (KW > COUNT_BITS) ? KW : COUNT_BITS;
  localparam int PW = pnws_pkg::PitchOut;

  localparam logic [CW-1:0] LimitC    = CW'(pnws_pkg::CycleLimit);
  localparam logic [8:0]    NodeLimit = 9'(NODES);

  // sequencer states
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StPrep  = 4'd1;
  localparam logic [3:0] StLoad  = 4'd2;
  localparam logic [3:0] StDiv   = 4'd3;
  localparam logic [3:0] StMax   = 4'd4;
  localparam logic [3:0] StSub   = 4'd5;
  localparam logic [3:0] StClamp = 4'd6;
  localparam logic [3:0] StAcc   = 4'd7;
  localparam logic [3:0] StOut   = 4'd8;

  // division operations
  localparam logic [1:0] OpFirstEnd   = 2'd0;
  localparam logic [1:0] OpFirstStart = 2'd1;
  localparam logic [1:0] OpLast       = 2'd2;

  // configuration registers
  logic [pnws_pkg::NodeBits-1:0] sel_q;
  logic signed [TW-1:0]          from_q;
  logic signed [TW-1:0]          to_q;
  logic [TW-2:0]                 perf_q;

  // control and sums
  logic [3:0]            state_q, state_d;
  logic [1:0]            op_q, op_d;
  logic [COUNT_BITS-1:0] acc_count_q, acc_count_d;
  logic [PW-1:0]         acc_low_q, acc_low_d;
  logic [PW-1:0]         acc_high_q, acc_high_d;
  logic                  out_valid_q, out_valid_d;

  // item payload
  logic signed [TW-1:0]  s_q, e_q, eff_to_q;
  logic [TW-2:0]         p_q;
  logic [PW-1:0]         pitch_q;
  logic                  last_q, hit_q;
  logic [KW-1:0]         ka_q, ka_d, kb_q, kb_d, ke_q, ke_d;
  logic [KW-1:0]         raw_q, raw_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [COUNT_BITS-1:0] out_count_q;
  logic [PW-1:0]         out_low_q, out_high_q;

  logic                  accept;
  logic                  node_ok;
  logic                  hit_in;
  logic signed [TW-1:0]  perf_s;
  logic signed [TW-1:0]  eff_to_in;

  logic signed [TW-1:0]  tgt, base;
  logic                  incl, skip;
  logic [TW-1:0]         dvd;
  logic                  div_start;
  logic                  div_done;
  logic [TW-1:0]         div_quot;
  logic                  div_rem_nz;
  logic [CW-1:0]         q_c, k_c;
  logic [KW-1:0]         k_new;
  logic                  k_wr;
  logic [KW-1:0]         k_val;
  logic [COUNT_BITS-1:0] room;
  logic                  out_load;

  assign accept = in_valid_i & in_ready_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q  <= '0;
      from_q <= '0;
      to_q   <= '0;
      perf_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pnws_pkg::RegSelectedNode: sel_q  <= cfg_data_i[pnws_pkg::NodeBits-1:0];
        pnws_pkg::RegWindowFrom:   from_q <= cfg_data_i;
        pnws_pkg::RegWindowTo:     to_q   <= cfg_data_i;
        pnws_pkg::RegPerfEnd:      perf_q <= cfg_data_i[TW-2:0];
        default: ;
      endcase
    end
  end

  // item qualification and window end clipping at accept
  assign node_ok   = {3'b000, sel_q} < NodeLimit;
  assign hit_in    = node_ok && (event_node_i == sel_q) && !event_pitch_i[pnws_pkg::PitchBits-1];
  assign perf_s    = signed'({1'b0, perf_q});
  assign eff_to_in = ((perf_q != '0) && (perf_s < to_q)) ? perf_s : to_q;

  // operands of the current ceiling division
  always_comb begin
    unique case (op_q)
      OpFirstEnd: begin
        tgt  = from_q;
        base = e_q;
        incl = 1'b0;
      end
      OpFirstStart: begin
        tgt  = '0;
        base = s_q;
        incl = 1'b1;
      end
      default: begin
        tgt  = eff_to_q;
        base = s_q;
        incl = 1'b1;
      end
    endcase
  end

  assign skip      = incl ? (base >= tgt) : (base > tgt);
  assign dvd       = TW'(tgt - base);
  assign div_start = (state_q == StLoad) && !skip;

  pnws_div #(
    .W (TW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd),
    .divisor_i  (p_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_nz_o   (div_rem_nz)
  );

  // repeat index from the quotient, with the ceiling rule and the limit
  assign q_c   = CW'(div_quot);
  assign k_c   = (q_c >= LimitC) ? LimitC
               : q_c + CW'((op_q == OpFirstEnd) ? 1'b1 : div_rem_nz);
  assign k_new = k_c[KW-1:0];

  assign room     = ~acc_count_q;
  assign out_load = (state_q == StOut) && (!out_valid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    acc_count_d = acc_count_q;
    acc_low_d   = acc_low_q;
    acc_high_d  = acc_high_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ka_d        = ka_q;
    kb_d        = kb_q;
    ke_d        = ke_q;
    raw_d       = raw_q;
    cnt_d       = cnt_q;
    k_wr        = 1'b0;
    k_val       = '0;

    unique case (state_q)
      StIdle: begin
        if (accept) state_d = StPrep;
      end
      StPrep: begin
        if (!hit_q || (from_q >= eff_to_q)) begin
          raw_d   = '0;
          state_d = StClamp;
        end else if (p_q == '0) begin
          raw_d   = KW'(!s_q[TW-1] && (s_q < eff_to_q) && (e_q > from_q));
          state_d = StClamp;
        end else begin
          op_d    = OpFirstEnd;
          state_d = StLoad;
        end
      end
      StLoad: begin
        if (skip) begin
          k_wr  = 1'b1;
          k_val = '0;
        end else begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (div_done) begin
          k_wr    = 1'b1;
          k_val   = k_new;
          state_d = StLoad;
        end
      end
      StMax: begin
        if (kb_q > ka_q) ka_d = kb_q;
        state_d = StSub;
      end
      StSub: begin
        raw_d   = (ke_q > ka_q) ? (ke_q - ka_q) : '0;
        state_d = StClamp;
      end
      StClamp: begin
        cnt_d   = (MW'(raw_q) > MW'(room)) ? room : COUNT_BITS'(raw_q);
        state_d = StAcc;
      end
      StAcc: begin
        if (cnt_q != '0) begin
          if ((acc_count_q == '0) || (pitch_q < acc_low_q)) acc_low_d = pitch_q;
          if ((acc_count_q == '0) || (pitch_q > acc_high_q)) acc_high_d = pitch_q;
          acc_count_d = acc_count_q + cnt_q;
        end
        state_d = last_q ? StOut : StIdle;
      end
      StOut: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          acc_count_d = '0;
          acc_low_d   = '0;
          acc_high_d  = '0;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    // store the finished repeat index and move to the next division
    if (k_wr) begin
      unique case (op_q)
        OpFirstEnd:   ka_d = k_val;
        OpFirstStart: kb_d = k_val;
        default:      ke_d = k_val;
      endcase
      if (op_q == OpLast) begin
        state_d = StMax;
      end else begin
        op_d    = op_q + 2'd1;
        state_d = StLoad;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      op_q        <= OpFirstEnd;
      acc_count_q <= '0;
      acc_low_q   <= '0;
      acc_high_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      acc_count_q <= acc_count_d;
      acc_low_q   <= acc_low_d;
      acc_high_q  <= acc_high_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item and working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_q      <= event_start_i;
      e_q      <= event_end_i;
      p_q      <= event_period_i;
      pitch_q  <= event_pitch_i[PW-1:0];
      last_q   <= is_last_i;
      hit_q    <= hit_in;
      eff_to_q <= eff_to_in;
    end
    ka_q  <= ka_d;
    kb_q  <= kb_d;
    ke_q  <= ke_d;
    raw_q <= raw_d;
    cnt_q <= cnt_d;
    if (out_load) begin
      out_count_q <= acc_count_q;
      out_low_q   <= acc_low_q;
      out_high_q  <= acc_high_q;
    end
  end

  assign in_ready_o      = (state_q == StIdle);
  assign out_valid_o     = out_valid_q;
  assign note_count_o    = out_count_q;
  assign lowest_pitch_o  = out_low_q;
  assign highest_pitch_o = out_high_q;

`ifndef SYNTHESIS
  // divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StDiv))
    else $error("divider done outside division wait");

  // pitch range of a result is ordered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (lowest_pitch_o <= highest_pitch_o))
    else $error("lowest pitch above highest pitch");

  // an empty result carries zero pitches
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (note_count_o == '0))
      |-> ((lowest_pitch_o == '0) && (highest_pitch_o == '0)))
    else $error("empty result with nonzero pitch");

  // sums are cleared right after a result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (acc_count_q == '0))
    else $error("sums not cleared after result");
`endif

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TimeBits      = pnws_pkg::TimeBitsDefault;
  localparam int CountBits     = pnws_pkg::CountBitsDefault;
  localparam int NodeBits      = pnws_pkg::NodeBits;
  localparam int PitchBits     = pnws_pkg::PitchBits;
  localparam int PitchOut      = pnws_pkg::PitchOut;
  localparam int CfgIdxBits    = pnws_pkg::CfgIdxBits;
  localparam logic [63:0] CycleLimit = pnws_pkg::CycleLimit;
  localparam int SettleCycles  = 200;
  localparam int LongHold      = 600;
  localparam int WatchdogLimit = 3000;
  localparam int PhaseCount    = 12;
  localparam int PhaseItems    = 72;

  localparam logic [TimeBits-1:0] MinTime = 48'h8000_0000_0000;
  localparam logic [TimeBits-1:0] MaxTime = 48'h7FFF_FFFF_FFFF;
  localparam logic [TimeBits-1:0] MaxSpan = 48'h7FFF_FFFF_FFFF;

  typedef struct {
    logic [NodeBits-1:0]         node;
    logic signed [TimeBits-1:0]  t_start;
    logic signed [TimeBits-1:0]  t_end;
    logic [TimeBits-2:0]         period;
    logic signed [PitchBits-1:0] pitch;
    logic                        last;
  } note_event_t;

  typedef struct {
    logic [CountBits-1:0] count;
    logic [PitchOut-1:0]  low;
    logic [PitchOut-1:0]  high;
  } summary_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [TimeBits-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [NodeBits-1:0] event_node_i = '0;
  logic signed [TimeBits-1:0] event_start_i = '0;
  logic signed [TimeBits-1:0] event_end_i = '0;
  logic [TimeBits-2:0] event_period_i = '0;
  logic signed [PitchBits-1:0] event_pitch_i = '0;
  logic is_last_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [CountBits-1:0] note_count_o;
  logic [PitchOut-1:0] lowest_pitch_o;
  logic [PitchOut-1:0] highest_pitch_o;

  periodic_note_window_summary uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .event_node_i   (event_node_i),
    .event_start_i  (event_start_i),
    .event_end_i    (event_end_i),
    .event_period_i (event_period_i),
    .event_pitch_i  (event_pitch_i),
    .is_last_i      (is_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .note_count_o   (note_count_o),
    .lowest_pitch_o (lowest_pitch_o),
    .highest_pitch_o(highest_pitch_o)
  );

  always #2 clk_i = ~clk_i;

  // predictor copy of the registers and the running summary
  logic [NodeBits-1:0] sel_node = '0;
  longint win_from = 0;
  longint win_to = 0;
  longint perf_lim = 0;
  longint unsigned sum_count = 0;
  logic [PitchOut-1:0] sum_low = '0;
  logic [PitchOut-1:0] sum_high = '0;

  note_event_t pending_q[$];
  summary_t summary_q[$];

  note_event_t drv_ev;
  note_event_t seen_ev;
  summary_t want;
  bit in_taken = 1'b0;
  bit calm = 1'b0;
  int tx_gap = 0;
  int rx_gap = 0;
  int hold_left = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int idle_cycles = 0;
  int errors = 0;

  // smallest repeat index k in [0, CycleLimit] with s + k*p reaching t
  function automatic longint unsigned repeat_index(longint s, longint unsigned p, longint t,
                                                   bit incl);
    longint unsigned d;
    longint unsigned q;
    longint unsigned k;
    if (incl ? (s >= t) : (s > t)) return 64'd0;
    d = longint'(t - s);
    q = d / p;
    if (q >= CycleLimit) return CycleLimit;
    if (incl) k = q + ((d % p != 0) ? 64'd1 : 64'd0);
    else k = q + 64'd1;
    return (k > CycleLimit) ? CycleLimit : k;
  endfunction

  // fold one accepted item into the summary, queue the summary on the last one
  function automatic void tally_event(note_event_t ev);
    longint s;
    longint e;
    longint t_to;
    longint unsigned per;
    longint unsigned first_k;
    longint unsigned stop_k;
    longint unsigned occ;
    longint unsigned room;
    logic [PitchOut-1:0] pv;
    summary_t res;
    s = longint'(ev.t_start);
    e = longint'(ev.t_end);
    per = 64'(ev.period);
    t_to = win_to;
    if (perf_lim > 0 && perf_lim < t_to) t_to = perf_lim;
    if (ev.node == sel_node && ev.pitch >= 0 && win_from < t_to) begin
      if (per != 0) begin
        first_k = repeat_index(e, per, win_from, 1'b0);
        stop_k = repeat_index(s, per, 0, 1'b1);
        if (stop_k > first_k) first_k = stop_k;
        stop_k = repeat_index(s, per, t_to, 1'b1);
        occ = (stop_k > first_k) ? stop_k - first_k : 64'd0;
      end else begin
        occ = (s >= 0 && s < t_to && e > win_from) ? 64'd1 : 64'd0;
      end
      // saturating count: a contribution cut to zero leaves the pitch range alone
      room = 64'hFFFF_FFFF - sum_count;
      if (occ > room) occ = room;
      if (occ != 0) begin
        pv = ev.pitch[PitchOut-1:0];
        if (sum_count == 0 || pv < sum_low) sum_low = pv;
        if (sum_count == 0 || pv > sum_high) sum_high = pv;
        sum_count += occ;
      end
    end
    if (ev.last) begin
      res.count = sum_count[CountBits-1:0];
      res.low = sum_low;
      res.high = sum_high;
      summary_q.push_back(res);
      sum_count = 0;
      sum_low = '0;
      sum_high = '0;
    end
  endfunction

  task automatic flag_error(string what, longint unsigned want_v, longint unsigned got_v);
    errors++;
    if (errors <= 10)
      $display("mismatch %s: expected %0d got %0d at %0t", what, want_v, got_v, $realtime);
  endtask

  // item driver, changes at the falling edge
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() != 0) begin
        drv_ev = pending_q.pop_front();
        event_node_i <= drv_ev.node;
        event_start_i <= drv_ev.t_start;
        event_end_i <= drv_ev.t_end;
        event_period_i <= drv_ev.period;
        event_pitch_i <= drv_ev.pitch;
        is_last_i <= drv_ev.last;
        in_valid_i <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) tx_gap = $urandom_range(1, 7);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver: random stall bursts plus the long hold-off on request
  always @(negedge clk_i) begin
    if (holds_done < holds_asked) begin
      hold_left = LongHold;
      holds_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      rx_gap = $urandom_range(0, 6);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // monitor: check results first, then predict from the accepted item
  always @(posedge clk_i) begin
    in_taken = in_valid_i && in_ready_o;
    if (out_valid_o && out_ready_i) begin
      if (summary_q.size() == 0) begin
        flag_error("result with none pending, note_count", 0, note_count_o);
      end else begin
        want = summary_q.pop_front();
        if (note_count_o !== want.count) flag_error("note_count", want.count, note_count_o);
        if (lowest_pitch_o !== want.low) flag_error("lowest_pitch", want.low, lowest_pitch_o);
        if (highest_pitch_o !== want.high)
          flag_error("highest_pitch", want.high, highest_pitch_o);
      end
    end
    if (in_taken) begin
      seen_ev.node = event_node_i;
      seen_ev.t_start = event_start_i;
      seen_ev.t_end = event_end_i;
      seen_ev.period = event_period_i;
      seen_ev.pitch = event_pitch_i;
      seen_ev.last = is_last_i;
      tally_event(seen_ev);
    end
    if (in_taken || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
  end

  // watchdog on cycles with no item moving
  initial begin
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("timeout after %0d cycles with no item accepted", WatchdogLimit);
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [TimeBits-1:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TimeBits-1:0];
  endfunction

  // wait until every item is in and every summary is out, then let the block drain
  task automatic settle();
    while (pending_q.size() != 0 || in_valid_i || summary_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxBits-1:0] idx, logic [TimeBits-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      pnws_pkg::RegSelectedNode: sel_node = data[NodeBits-1:0];
      pnws_pkg::RegWindowFrom:   win_from = $signed(data);
      pnws_pkg::RegWindowTo:     win_to = $signed(data);
      pnws_pkg::RegPerfEnd:      perf_lim = longint'(data[TimeBits-2:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_setup(logic [TimeBits-1:0] node_w, logic [TimeBits-1:0] from_w,
                             logic [TimeBits-1:0] to_w, logic [TimeBits-1:0] perf_w);
    settle();
    cfg_write(pnws_pkg::RegSelectedNode, node_w);
    cfg_write(pnws_pkg::RegWindowFrom, from_w);
    cfg_write(pnws_pkg::RegWindowTo, to_w);
    cfg_write(pnws_pkg::RegPerfEnd, perf_w);
  endtask

  task automatic add_event(logic [NodeBits-1:0] node, logic [TimeBits-1:0] s,
                           logic [TimeBits-1:0] e, logic [TimeBits-2:0] p,
                           logic signed [PitchBits-1:0] pitch, logic last);
    note_event_t ev;
    ev.node = node;
    ev.t_start = s;
    ev.t_end = e;
    ev.period = p;
    ev.pitch = pitch;
    ev.last = last;
    pending_q.push_back(ev);
  endtask

  // mostly events of the selected node placed around the window edges and time zero
  function automatic note_event_t random_event(bit last);
    note_event_t ev;
    longint anchor;
    longint s;
    longint e;
    logic [TimeBits-1:0] wide;
    int unsigned pick;
    ev.node = ($urandom_range(0, 9) < 8) ? sel_node : NodeBits'($urandom);
    if ($urandom_range(0, 9) == 0) ev.pitch = -PitchBits'($urandom_range(1, 2));
    else ev.pitch = PitchBits'($urandom_range(0, 127));
    if ($urandom_range(0, 99) < 12) begin
      ev.t_start = rand48();
      ev.t_end = rand48();
    end else begin
      case ($urandom_range(0, 2))
        0: anchor = win_from;
        1: anchor = win_to;
        default: anchor = 0;
      endcase
      s = anchor + longint'($urandom_range(0, 40000)) - 20000;
      e = s + longint'($urandom_range(0, 4100)) - 100;
      ev.t_start = s[TimeBits-1:0];
      ev.t_end = e[TimeBits-1:0];
    end
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      ev.period = '0;
    end else if (pick < 35) begin
      ev.period = (TimeBits-1)'(1);
    end else if (pick < 90) begin
      ev.period = (TimeBits-1)'($urandom_range(2, 3000));
    end else begin
      wide = rand48() >> $urandom_range(1, 47);
      ev.period = (wide == '0) ? (TimeBits-1)'(1) : wide[TimeBits-2:0];
    end
    ev.last = last;
    return ev;
  endfunction

  initial begin
    int phase;
    int i;
    longint from_v;
    longint to_v;
    logic [TimeBits-1:0] node_w;
    logic [TimeBits-1:0] from_w;
    logic [TimeBits-1:0] to_w;
    logic [TimeBits-1:0] perf_w;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // window still empty after reset: nothing counts, summary is all zero
    add_event(6'd0, 48'd0, 48'd10, 47'd0, 8'sd10, 1'b0);
    add_event(6'd0, 48'd0, 48'd10, 47'd0, 8'sd10, 1'b1);

    // plain window: single shots, skipped items, a repeat and an inverted span
    apply_setup(48'd5, 48'd100, 48'd1000, 48'd0);
    add_event(6'd5, 48'd200, 48'd300, 47'd0, 8'sd60, 1'b0);
    add_event(6'd6, 48'd200, 48'd300, 47'd0, 8'sd20, 1'b0);
    add_event(6'd5, 48'd200, 48'd300, 47'd0, -8'sd1, 1'b0);
    add_event(6'd5, 48'd200, 48'd300, 47'd0, -8'sd2, 1'b0);
    add_event(6'd5, -48'sd5, 48'd500, 47'd0, 8'sd1, 1'b0);
    add_event(6'd5, 48'd0, 48'd10, 47'd100, 8'sd127, 1'b0);
    add_event(6'd5, 48'd500, 48'd100, 47'd50, 8'sd3, 1'b0);
    add_event(6'd5, 48'd200, 48'd300, 47'd0, 8'sd0, 1'b1);
    add_event(6'd5, MinTime, MaxTime, MaxSpan[TimeBits-2:0], 8'sd64, 1'b0);
    add_event(6'd5, MaxTime, MinTime, 47'd1, 8'sd99, 1'b1);

    // widest window: count saturates, then a clipped item leaves the pitches alone
    apply_setup(48'd63, MinTime, MaxTime, 48'd0);
    add_event(6'd63, MinTime, MaxTime, 47'd1, 8'sd127, 1'b0);
    add_event(6'd63, 48'd0, 48'd1, 47'd1, 8'sd0, 1'b0);
    add_event(6'd0, 48'd0, 48'd1, 47'd1, 8'sd5, 1'b1);

    // performance end clips the window; node register carries junk upper bits
    apply_setup(48'hABCD_EF12_34FF, 48'd0, 48'd10000, 48'd500);
    add_event(6'd63, 48'd0, 48'd50, 47'd100, 8'sd40, 1'b0);
    add_event(6'd63, 48'd600, 48'd700, 47'd0, 8'sd41, 1'b1);

    // clipping empties the window
    apply_setup(48'd0, 48'd600, 48'd10000, 48'h8000_0000_01F4);
    add_event(6'd0, 48'd0, 48'd1000, 47'd10, 8'sd50, 1'b1);

    // negative window start, repeats that start before time zero
    apply_setup(48'd1, -48'sd1000, 48'd50, MaxSpan);
    add_event(6'd1, -48'sd3000, -48'sd2500, 47'd700, 8'sd20, 1'b0);
    add_event(6'd1, -48'sd10, 48'd5, 47'd0, 8'sd2, 1'b0);
    add_event(6'd1, 48'd0, 48'd1, 47'd0, 8'sd127, 1'b1);

    // random phases over several register settings
    for (phase = 0; phase < PhaseCount; phase++) begin
      case (phase % 4)
        0, 1: begin
          node_w = TimeBits'($urandom_range(0, 63));
          if ($urandom_range(0, 3) == 0) node_w = rand48();
          from_v = longint'($urandom_range(0, 4000)) - 2000;
          to_v = from_v + longint'($urandom_range(0, 60000)) - 3000;
          from_w = from_v[TimeBits-1:0];
          to_w = to_v[TimeBits-1:0];
          perf_w = $urandom_range(0, 1) ? 48'd0 : 48'($urandom_range(1, 70000));
        end
        2: begin
          node_w = $urandom_range(0, 1) ? 48'd63 : 48'd0;
          case ($urandom_range(0, 2))
            0: begin from_w = MinTime; to_w = MaxTime; perf_w = 48'd0; end
            1: begin from_w = MaxTime; to_w = MinTime; perf_w = 48'd1; end
            default: begin from_w = MinTime; to_w = MaxTime; perf_w = MaxSpan; end
          endcase
        end
        default: begin
          node_w = rand48();
          from_w = rand48();
          to_w = rand48();
          perf_w = rand48();
        end
      endcase
      apply_setup(node_w, from_w, to_w, perf_w);
      if (phase == 3 || phase == 7) holds_asked++;
      if (phase == PhaseCount - 1) calm = 1'b1;
      // during a long hold two early last items make the second one block the input
      for (i = 0; i < PhaseItems; i++)
        pending_q.push_back(random_event(i == PhaseItems - 1 ||
                                         ((phase == 3 || phase == 7) && i < 2) ||
                                         $urandom_range(0, 5) == 0));
    end

    settle();
    if (summary_q.size() != 0) flag_error("results never delivered", 0, summary_q.size());
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
